>>> rtl/core/psb_pkg.sv
package psb_pkg;

  // Default sizes of the stores.
  localparam int MAX_FRAMES_DEF  = 4;
  localparam int MAX_ROWS_DEF    = 256;
  localparam int MAX_COLUMNS_DEF = 256;

  // Field widths of the stream items.
  localparam int MODE_W     = 2;
  localparam int FRAME_W    = 2;
  localparam int ROW_W      = 8;
  localparam int COLUMN_W   = 8;
  localparam int SAMPLE_W   = 16;
  localparam int BIN_X_W    = 10;
  localparam int BIN_Y_W    = 8;
  localparam int SUM_W      = 32;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 32;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_SHIFT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SKIP_PEDESTAL = 3'd4;

  localparam logic [2:0] FRAME_COUNT_RST  = 3'd1;
  localparam logic [8:0] ROW_COUNT_RST    = 9'd256;
  localparam logic [8:0] COLUMN_COUNT_RST = 9'd256;
  localparam logic [2:0] BIN_SHIFT_RST    = 3'd0;
  localparam logic [2:0] BIN_SHIFT_MAX    = 3'd4;

  // Calibration offset added to every pixel.
  localparam logic [SAMPLE_W:0] CAL_OFFSET = 17'h10000;

  // Depth of the command queue and of the result buffer.
  localparam int Q_DEPTH   = 4;
  localparam int OUT_DEPTH = 3;

  typedef enum logic [MODE_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_ACC   = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  // Classified command passed from the front to the back.
  typedef struct packed {
    op_t                 op;
    logic                sub_ped;  // subtract the pedestal word
    logic                rd_zero;  // read lies outside the image
    logic [SAMPLE_W-1:0] sample;
  } cmd_t;

endpackage

>>> rtl/core/psb_front.sv
module psb_front #(
  parameter int MAX_FRAMES  = psb_pkg::MAX_FRAMES_DEF,
  parameter int MAX_ROWS    = psb_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLUMNS = psb_pkg::MAX_COLUMNS_DEF,
  localparam int FAW    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1,
  localparam int RAW    = $clog2(MAX_ROWS),
  localparam int CAW    = $clog2(MAX_COLUMNS),
  localparam int XW     = $clog2(MAX_FRAMES * MAX_COLUMNS),
  localparam int PED_AW = FAW + RAW + CAW,
  localparam int BIN_AW = RAW + XW
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [psb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [psb_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [psb_pkg::MODE_W-1:0]       in_tuser,
  input  logic [psb_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic                             boot_busy,
  input  logic                             q_full,
  output logic                             q_push,
  output psb_pkg::cmd_t                    q_cmd,
  output logic [PED_AW-1:0]                q_ped_addr,
  output logic [BIN_AW-1:0]                q_bin_addr
);
  import psb_pkg::*;

  localparam int IMG_W = MAX_FRAMES * MAX_COLUMNS;
  localparam int NFW   = $clog2(MAX_FRAMES + 1);
  localparam int NRW   = $clog2(MAX_ROWS + 1);
  localparam int NCW   = $clog2(MAX_COLUMNS + 1);
  localparam int XFW   = NCW + 3;

  logic [2:0] frame_count_r;
  logic [8:0] row_count_r;
  logic [8:0] column_count_r;
  logic [2:0] bin_shift_r;
  logic       skip_r;

  logic [FRAME_W-1:0]  frame;
  logic [ROW_W-1:0]    row;
  logic [COLUMN_W-1:0] column;
  logic [SAMPLE_W-1:0] sample;
  logic [BIN_X_W-1:0]  bin_x;
  logic [BIN_Y_W-1:0]  bin_y;
  op_t                 mode;

  logic [NFW-1:0] nf;
  logic [NRW-1:0] nr;
  logic [NCW-1:0] nc;
  logic [2:0]     sh;
  logic [XFW-1:0] x_full;
  logic [XW-1:0]  pix_x;
  logic [RAW-1:0] pix_y;
  logic           keep;
  logic           accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r  <= FRAME_COUNT_RST;
      row_count_r    <= ROW_COUNT_RST;
      column_count_r <= COLUMN_COUNT_RST;
      bin_shift_r    <= BIN_SHIFT_RST;
      skip_r         <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_COUNT:   frame_count_r  <= cfg_wdata[2:0];
        CFG_ROW_COUNT:     row_count_r    <= cfg_wdata;
        CFG_COLUMN_COUNT:  column_count_r <= cfg_wdata;
        CFG_BIN_SHIFT:     bin_shift_r    <= cfg_wdata[2:0];
        CFG_SKIP_PEDESTAL: skip_r         <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign mode   = op_t'(in_tuser);
  assign frame  = in_tdata[1:0];
  assign row    = in_tdata[9:2];
  assign column = in_tdata[17:10];
  assign sample = in_tdata[33:18];
  assign bin_x  = in_tdata[43:34];
  assign bin_y  = in_tdata[51:44];

  // Saturate the frame geometry to the store sizes, a zero count to one, and the bin shift to its maximum.
  always_comb begin
    if (frame_count_r == 3'd0) nf = NFW'(1);
    else if (32'(frame_count_r) > 32'(MAX_FRAMES)) nf = NFW'(MAX_FRAMES);
    else nf = NFW'(frame_count_r);

    if (row_count_r == 9'd0) nr = NRW'(1);
    else if (32'(row_count_r) > 32'(MAX_ROWS)) nr = NRW'(MAX_ROWS);
    else nr = NRW'(row_count_r);

    if (column_count_r == 9'd0) nc = NCW'(1);
    else if (32'(column_count_r) > 32'(MAX_COLUMNS)) nc = NCW'(MAX_COLUMNS);
    else nc = NCW'(column_count_r);

    sh = (bin_shift_r > BIN_SHIFT_MAX) ? BIN_SHIFT_MAX : bin_shift_r;
  end

  // Frames sit side by side, so a frame starts nc columns after the previous one.
  // An in-frame pixel always lands inside the image, no range check is needed.
  assign x_full = XFW'(column) + XFW'(nc) * XFW'(frame);
  assign pix_x  = XW'(x_full >> sh);
  assign pix_y  = RAW'(row >> sh);

  always_comb begin
    q_cmd.op      = mode;
    q_cmd.sub_ped = !skip_r;
    q_cmd.rd_zero = !((32'(bin_x) < 32'(IMG_W)) && (32'(bin_y) < 32'(MAX_ROWS)));
    q_cmd.sample  = sample;
    q_ped_addr    = {FAW'(frame), RAW'(row), CAW'(column)};
    q_bin_addr    = {RAW'(bin_y), XW'(bin_x)};
    case (mode)
      OP_LOAD: begin
        keep = (32'(frame) < 32'(MAX_FRAMES)) && (32'(row) < 32'(MAX_ROWS)) &&
               (32'(column) < 32'(MAX_COLUMNS));
      end
      OP_ACC: begin
        keep       = (32'(frame) < 32'(nf)) && (32'(row) < 32'(nr)) &&
                     (32'(column) < 32'(nc));
        q_bin_addr = {pix_y, pix_x};
      end
      OP_READ:  keep = 1'b1;
      OP_CLEAR: keep = 1'b1;
      default:  keep = 1'b0;
    endcase
  end

  assign in_tready = !boot_busy && !q_full;
  assign accept    = in_tvalid && in_tready;
  assign q_push    = accept && keep;

endmodule

>>> rtl/core/psb_queue.sv
module psb_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = psb_pkg::Q_DEPTH,
  localparam int PW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] pop_data
);
  import psb_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  assign full     = (count_r == CW'(DEPTH));
  assign valid    = (count_r != '0);
  assign pop_data = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("queue written while full");

  a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> count_r == $past(count_r) - 1'b1)
    else $error("queue count lost a pop");

endmodule

>>> rtl/core/psb_back.sv
module psb_back #(
  parameter int MAX_FRAMES  = psb_pkg::MAX_FRAMES_DEF,
  parameter int MAX_ROWS    = psb_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLUMNS = psb_pkg::MAX_COLUMNS_DEF,
  localparam int FAW    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1,
  localparam int RAW    = $clog2(MAX_ROWS),
  localparam int CAW    = $clog2(MAX_COLUMNS),
  localparam int XW     = $clog2(MAX_FRAMES * MAX_COLUMNS),
  localparam int PED_AW = FAW + RAW + CAW,
  localparam int BIN_AW = RAW + XW
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_valid,
  input  psb_pkg::cmd_t                   q_cmd,
  input  logic [PED_AW-1:0]               q_ped_addr,
  input  logic [BIN_AW-1:0]               q_bin_addr,
  output logic                            q_pop,
  output logic                            boot_busy,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [psb_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import psb_pkg::*;

  localparam int OPW = $clog2(OUT_DEPTH);
  localparam int OCW = $clog2(OUT_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_BOOT  = 3'b001,
    ST_RUN   = 3'b010,
    ST_SWEEP = 3'b100
  } bstate_t;

  bstate_t state_r, state_nxt;
  logic [BIN_AW-1:0] sw_r, sw_nxt;
  logic              sweeping;

  logic [SAMPLE_W-1:0] ped_mem [2**PED_AW];
  logic [SUM_W-1:0]    bin_mem [2**BIN_AW];
  logic [SAMPLE_W-1:0] ped_q_r;
  logic [SUM_W-1:0]    bin_q_r;

  // Second stage: the item whose store reads are in flight.
  logic                b1_valid_r, b1_valid_nxt;
  op_t                 b1_op_r;
  logic                b1_sub_r;
  logic                b1_zero_r;
  logic [SAMPLE_W-1:0] b1_sample_r;
  logic [BIN_AW-1:0]   b1_bin_addr_r;
  logic                fwd_r, fwd_nxt;
  logic [SUM_W-1:0]    fwd_data_r;

  logic                b1_acc, b1_rd;
  logic [SUM_W-1:0]    old_sum, new_sum;
  logic [SAMPLE_W-1:0] ped_term;
  logic [SAMPLE_W:0]   cal_val;
  logic                room;

  logic              bin_we;
  logic [BIN_AW-1:0] bin_wa;
  logic [SUM_W-1:0]  bin_wd;

  logic [SUM_W-1:0] ob_mem [OUT_DEPTH];
  logic [OPW-1:0]   ob_wr_r, ob_rd_r;
  logic [OCW-1:0]   ob_cnt_r, ob_cnt_nxt;
  logic             ob_push, ob_pop;

  assign sweeping  = (state_r == ST_BOOT) || (state_r == ST_SWEEP);
  assign boot_busy = (state_r == ST_BOOT);

  assign b1_acc = b1_valid_r && (b1_op_r == OP_ACC);
  assign b1_rd  = b1_valid_r && (b1_op_r == OP_READ);

  // A read leaves only when the result buffer has a slot for it,
  // counting the read already in the second stage.
  assign room  = (3'(ob_cnt_r) + 3'(b1_rd)) < 3'(OUT_DEPTH);
  assign q_pop = (state_r == ST_RUN) && q_valid && ((q_cmd.op != OP_READ) || room);

  always_comb begin
    state_nxt = state_r;
    sw_nxt    = sw_r;
    case (state_r)
      ST_BOOT, ST_SWEEP: begin
        sw_nxt = sw_r + 1'b1;
        if (sw_r == '1) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (q_pop && (q_cmd.op == OP_CLEAR)) state_nxt = ST_SWEEP;
      end
      default: state_nxt = ST_BOOT;
    endcase
  end

  // Calibrate and accumulate.
  assign old_sum  = fwd_r ? fwd_data_r : bin_q_r;
  assign ped_term = b1_sub_r ? ped_q_r : '0;
  assign cal_val  = CAL_OFFSET + {1'b0, b1_sample_r} - {1'b0, ped_term};
  assign new_sum  = old_sum + SUM_W'(cal_val);

  assign b1_valid_nxt = q_pop && ((q_cmd.op == OP_ACC) || (q_cmd.op == OP_READ));
  assign fwd_nxt      = b1_valid_nxt && b1_acc && (q_bin_addr == b1_bin_addr_r);

  assign bin_we = sweeping || b1_acc;
  assign bin_wa = sweeping ? sw_r : b1_bin_addr_r;
  assign bin_wd = sweeping ? '0 : new_sum;

  always_ff @(posedge clk) begin
    if (q_pop && (q_cmd.op == OP_LOAD)) ped_mem[q_ped_addr] <= q_cmd.sample;
    if (q_pop) ped_q_r <= ped_mem[q_ped_addr];
  end

  always_ff @(posedge clk) begin
    if (bin_we) bin_mem[bin_wa] <= bin_wd;
    if (q_pop) bin_q_r <= bin_mem[q_bin_addr];
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      b1_op_r       <= q_cmd.op;
      b1_sub_r      <= q_cmd.sub_ped;
      b1_zero_r     <= q_cmd.rd_zero;
      b1_sample_r   <= q_cmd.sample;
      b1_bin_addr_r <= q_bin_addr;
    end
    fwd_data_r <= new_sum;
  end

  // Result buffer.
  assign ob_push    = b1_rd;
  assign ob_pop     = out_tvalid && out_tready;
  assign out_tvalid = (ob_cnt_r != '0);
  assign out_tdata  = ob_mem[ob_rd_r];

  always_comb begin
    ob_cnt_nxt = ob_cnt_r;
    if (ob_push && !ob_pop) ob_cnt_nxt = ob_cnt_r + 1'b1;
    else if (ob_pop && !ob_push) ob_cnt_nxt = ob_cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (ob_push) ob_mem[ob_wr_r] <= b1_zero_r ? '0 : old_sum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_BOOT;
      sw_r       <= '0;
      b1_valid_r <= 1'b0;
      fwd_r      <= 1'b0;
      ob_wr_r    <= '0;
      ob_rd_r    <= '0;
      ob_cnt_r   <= '0;
    end else begin
      state_r    <= state_nxt;
      sw_r       <= sw_nxt;
      b1_valid_r <= b1_valid_nxt;
      fwd_r      <= fwd_nxt;
      ob_cnt_r   <= ob_cnt_nxt;
      if (ob_push) ob_wr_r <= (ob_wr_r == OPW'(OUT_DEPTH - 1)) ? '0 : ob_wr_r + 1'b1;
      if (ob_pop)  ob_rd_r <= (ob_rd_r == OPW'(OUT_DEPTH - 1)) ? '0 : ob_rd_r + 1'b1;
    end
  end

  a_no_write_clash: assert property (@(posedge clk) disable iff (!rst_n)
    sweeping |-> !b1_acc)
    else $error("accumulate write during bin sweep");

  a_pop_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> state_r == ST_RUN)
    else $error("command taken while sweeping");

  a_result_room: assert property (@(posedge clk) disable iff (!rst_n)
    (ob_push && !ob_pop) |-> ob_cnt_r != OCW'(OUT_DEPTH))
    else $error("result buffer overflow");

  a_fwd_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_r |-> b1_valid_r)
    else $error("forwarded sum without an item in the second stage");

endmodule

>>> rtl/core/pedestal_subtract_pixel_binner.sv
// A read item passes through the command queue and the second stage into the result buffer,
// whose head drives out_tdata. Throughput: one item per cycle for loads, pixels and reads
// while the back end is not sweeping and, for reads, the result buffer has room; the bin
// store's read-modify-write stage forwards its sum so back-to-back pixels to one bin keep pace.
// A clear item holds the back end while all 2**BIN_AW bin entries are swept (262144 by default).
// Reset is synchronous and active low; after it the bin store is swept to zero, in_tready low.
module pedestal_subtract_pixel_binner #(
  parameter int MAX_FRAMES  = psb_pkg::MAX_FRAMES_DEF,
  parameter int MAX_ROWS    = psb_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLUMNS = psb_pkg::MAX_COLUMNS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Configuration write port.
  input  logic                            cfg_we,
  input  logic [psb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [psb_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // Input items.
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [psb_pkg::MODE_W-1:0]      in_tuser,  // [1:0] mode
  // [1:0] frame, [9:2] row, [17:10] column, [33:18] sample,
  // [43:34] bin_x, [51:44] bin_y, [55:52] zero
  input  logic [psb_pkg::IN_DATA_W-1:0]   in_tdata,
  // Result items.
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [psb_pkg::OUT_DATA_W-1:0]  out_tdata  // [31:0] bin_sum
);
  import psb_pkg::*;

  localparam int FAW    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int RAW    = $clog2(MAX_ROWS);
  localparam int CAW    = $clog2(MAX_COLUMNS);
  localparam int XW     = $clog2(MAX_FRAMES * MAX_COLUMNS);
  localparam int PED_AW = FAW + RAW + CAW;
  localparam int BIN_AW = RAW + XW;
  localparam int QW     = PED_AW + BIN_AW + $bits(cmd_t);

  // The front decodes each item against the configuration, drops loads and
  // pixels that fall outside the stores or the configured frames, and turns
  // the rest into commands with store addresses already worked out.
  logic              q_push, q_full, q_pop, q_valid;
  cmd_t              f_cmd, b_cmd;
  logic [PED_AW-1:0] f_ped_addr, b_ped_addr;
  logic [BIN_AW-1:0] f_bin_addr, b_bin_addr;
  logic              boot_busy;

  psb_front #(
    .MAX_FRAMES  (MAX_FRAMES),
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .boot_busy  (boot_busy),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (f_cmd),
    .q_ped_addr (f_ped_addr),
    .q_bin_addr (f_bin_addr)
  );

  // The command queue lets the front keep taking items while the back end is
  // sweeping the bin store after a clear or waiting on a full result buffer.
  psb_queue #(
    .WIDTH (QW),
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data ({f_ped_addr, f_bin_addr, f_cmd}),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  ({b_ped_addr, b_bin_addr, b_cmd})
  );

  // The back end owns both stores. Pedestal loads write when they leave the
  // queue; pixels and reads fetch both stores, then a second stage adds the
  // calibrated value into the bin or hands the bin sum to the result buffer.
  psb_back #(
    .MAX_FRAMES  (MAX_FRAMES),
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_cmd      (b_cmd),
    .q_ped_addr (b_ped_addr),
    .q_bin_addr (b_bin_addr),
    .q_pop      (q_pop),
    .boot_busy  (boot_busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

>>> verif/tb.sv
module tb;
  import psb_pkg::*;

  // Image geometry used by the binning arithmetic.
  localparam int unsigned IMG_W = MAX_FRAMES_DEF * MAX_COLUMNS_DEF;

  // Writes to these indexes land on no register and must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = 3'd5;

  // Stimulus size and run limits. The watchdog covers the zeroing sweep after
  // reset, two clear items, and every item with the longest gaps and stalls,
  // and then some margin.
  localparam int unsigned ITEM_GOAL     = 1050;
  localparam int unsigned PHASE_ITEMS   = 110;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT   = 3_500_000;

  // One input item: mode travels on tuser, the rest packed in tdata with
  // frame in the lowest bits.
  typedef struct packed {
    logic [BIN_Y_W-1:0]  bin_y;
    logic [BIN_X_W-1:0]  bin_x;
    logic [SAMPLE_W-1:0] sample;
    logic [COLUMN_W-1:0] column;
    logic [ROW_W-1:0]    row;
    logic [FRAME_W-1:0]  frame;
  } pixel_word_t;

  localparam int WORD_W = $bits(pixel_word_t);

  typedef struct {
    op_t         mode;
    pixel_word_t word;
  } detector_item_t;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [MODE_W-1:0]      in_tuser;   // [1:0] mode
  // [1:0] frame, [9:2] row, [17:10] column, [33:18] sample,
  // [43:34] bin_x, [51:44] bin_y, [55:52] zero
  logic [IN_DATA_W-1:0]   in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_DATA_W-1:0]  out_tdata;  // [31:0] bin_sum

  pedestal_subtract_pixel_binner DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Shadow of the block: pedestal words that were loaded and nonzero bin sums.
  // A bin that is absent from the map holds zero.
  logic [SAMPLE_W-1:0] pedestal_words [int unsigned];
  logic [SUM_W-1:0]    bin_sums [int unsigned];
  logic [SUM_W-1:0]    sums_due [$];

  // Effective configuration, after the block's saturation of each register.
  int unsigned lim_frames, lim_rows, lim_cols, lim_shift;
  logic        lim_skip;

  // Generator bookkeeping: which pedestal entries have been loaded so far in
  // queue order, and which bins have taken a pixel since the last clear.
  bit          ped_loaded [int unsigned];
  int unsigned hit_keys [$];

  detector_item_t pending_items [$];
  detector_item_t item_on_bus;
  int unsigned    queued_items;
  int unsigned    accepted_items;
  int unsigned    sums_checked;
  int unsigned    fault_count;
  int unsigned    cycle_count;
  int unsigned    send_gap;
  int unsigned    recv_stall;
  logic           send_busy;
  logic [SUM_W-1:0] want_sum;

  // When set, the matching side runs without idle cycles for the phase.
  bit tx_calm;
  bit rx_calm;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report_fault(input string msg);
    fault_count++;
    $display("[cycle %0d] %s", cycle_count, msg);
  endtask

  function automatic int unsigned clamp_span(input int unsigned v, input int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // Record a register setting the way the block sees it: masked to the
  // register width and saturated to the supported range.
  function automatic void adopt_config(input int unsigned f, input int unsigned r,
                                       input int unsigned c, input int unsigned s,
                                       input int unsigned k);
    lim_frames = clamp_span(f & 32'h7, MAX_FRAMES_DEF);
    lim_rows   = clamp_span(r & 32'h1FF, MAX_ROWS_DEF);
    lim_cols   = clamp_span(c & 32'h1FF, MAX_COLUMNS_DEF);
    lim_shift  = ((s & 32'h7) > BIN_SHIFT_MAX) ? BIN_SHIFT_MAX : (s & 32'h7);
    lim_skip   = k[0];
  endfunction

  // Apply one accepted item to the shadow state; a read queues the sum it
  // must return.
  function automatic void binner_apply(input detector_item_t it);
    int unsigned spot;
    int unsigned x;
    int unsigned y;
    logic [SUM_W-1:0] gain;
    spot = {it.word.frame, it.word.row, it.word.column};
    case (it.mode)
      OP_LOAD: begin
        pedestal_words[spot] = it.word.sample;
      end
      OP_ACC: begin
        // Pixels outside the configured frame are dropped.
        if (it.word.frame < lim_frames && it.word.row < lim_rows &&
            it.word.column < lim_cols) begin
          gain = CAL_OFFSET + it.word.sample;
          if (!lim_skip && pedestal_words.exists(spot))
            gain = gain - pedestal_words[spot];
          // Frames sit side by side, so later frames shift right by a frame width.
          x = (it.word.column + lim_cols * it.word.frame) >> lim_shift;
          y = it.word.row >> lim_shift;
          if (x < IMG_W && y < MAX_ROWS_DEF) begin
            spot = y * IMG_W + x;
            bin_sums[spot] = (bin_sums.exists(spot) ? bin_sums[spot] : '0) + gain;
          end
        end
      end
      OP_READ: begin
        spot = it.word.bin_y * IMG_W + it.word.bin_x;
        if (it.word.bin_x < IMG_W && it.word.bin_y < MAX_ROWS_DEF &&
            bin_sums.exists(spot))
          sums_due.insert(sums_due.size(), bin_sums[spot]);
        else
          sums_due.insert(sums_due.size(), '0);
      end
      default: begin
        bin_sums.delete();
      end
    endcase
  endfunction

  // Every field of the word random and the mode a load; the queue helpers overwrite the ones that matter.
  function automatic detector_item_t noise_item();
    detector_item_t it;
    it.mode = OP_LOAD;
    it.word = WORD_W'({$urandom, $urandom});
    return it;
  endfunction

  function automatic logic [SAMPLE_W-1:0] draw_sample();
    if ($urandom_range(0, 9) == 0)
      return $urandom_range(0, 1) ? '1 : '0;
    return SAMPLE_W'($urandom);
  endfunction

  function automatic void queue_item(input detector_item_t it);
    pending_items.insert(pending_items.size(), it);
    queued_items++;
  endfunction

  function automatic void queue_load(input logic [FRAME_W-1:0] f, input logic [ROW_W-1:0] r,
                                     input logic [COLUMN_W-1:0] c,
                                     input logic [SAMPLE_W-1:0] s);
    detector_item_t it;
    it = noise_item();
    it.mode = OP_LOAD;
    it.word.frame = f;
    it.word.row = r;
    it.word.column = c;
    it.word.sample = s;
    ped_loaded[{f, r, c}] = 1'b1;
    queue_item(it);
  endfunction

  // A pixel that will be calibrated against its pedestal gets a load first
  // if its entry has never been written.
  function automatic void queue_pixel(input logic [FRAME_W-1:0] f, input logic [ROW_W-1:0] r,
                                      input logic [COLUMN_W-1:0] c,
                                      input logic [SAMPLE_W-1:0] s);
    detector_item_t it;
    bit in_frame;
    in_frame = (f < lim_frames) && (r < lim_rows) && (c < lim_cols);
    if (in_frame && !lim_skip && !ped_loaded.exists({f, r, c}))
      queue_load(f, r, c, draw_sample());
    it = noise_item();
    it.mode = OP_ACC;
    it.word.frame = f;
    it.word.row = r;
    it.word.column = c;
    it.word.sample = s;
    if (in_frame)
      hit_keys.insert(hit_keys.size(),
                      (r >> lim_shift) * IMG_W + ((c + lim_cols * f) >> lim_shift));
    queue_item(it);
  endfunction

  function automatic void queue_read(input logic [BIN_X_W-1:0] bx,
                                     input logic [BIN_Y_W-1:0] by);
    detector_item_t it;
    it = noise_item();
    it.mode = OP_READ;
    it.word.bin_x = bx;
    it.word.bin_y = by;
    queue_item(it);
  endfunction

  function automatic void queue_clear();
    detector_item_t it;
    it = noise_item();
    it.mode = OP_CLEAR;
    hit_keys.delete();
    queue_item(it);
  endfunction

  // Mostly read bins that have taken pixels; otherwise anywhere in the image.
  function automatic void queue_hit_read();
    int unsigned key;
    if (hit_keys.size() > 0 && $urandom_range(0, 3) != 0) begin
      key = hit_keys[$urandom_range(0, hit_keys.size() - 1)];
      queue_read(BIN_X_W'(key % IMG_W), BIN_Y_W'(key / IMG_W));
    end else begin
      queue_read(BIN_X_W'($urandom), BIN_Y_W'($urandom));
    end
  endfunction

  // Half of the in-frame pixels fall in a small corner of the configured frame so that bins
  // collect several of them; one in five is drawn over the whole field range.
  function automatic void queue_random_pixel();
    int unsigned f;
    int unsigned r;
    int unsigned c;
    bit hot;
    hot = $urandom_range(0, 1);
    if ($urandom_range(0, 4) == 0) begin
      f = $urandom;
      r = $urandom;
      c = $urandom;
    end else begin
      f = $urandom_range(0, lim_frames - 1);
      r = $urandom_range(0, (hot && lim_rows > 4) ? 3 : lim_rows - 1);
      c = $urandom_range(0, (hot && lim_cols > 4) ? 3 : lim_cols - 1);
    end
    queue_pixel(FRAME_W'(f), ROW_W'(r), COLUMN_W'(c), draw_sample());
  endfunction

  // Wait until every queued item has been taken and every read answered,
  // then give the back end time to finish items that return nothing.
  task automatic wait_idle();
    do @(posedge clk);
    while (accepted_items != queued_items || sums_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Called right after a rising edge. Each register write is held for one
  // edge; a write to an unused index goes first.
  task automatic configure(input int unsigned f, input int unsigned r, input int unsigned c,
                           input int unsigned s, input int unsigned k);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_IDX_W'(CFG_SPARE_FIRST + $urandom_range(0, 2));
    cfg_wdata <= CFG_DATA_W'($urandom);
    @(posedge clk);
    cfg_index <= CFG_FRAME_COUNT;
    cfg_wdata <= CFG_DATA_W'(f);
    @(posedge clk);
    cfg_index <= CFG_ROW_COUNT;
    cfg_wdata <= CFG_DATA_W'(r);
    @(posedge clk);
    cfg_index <= CFG_COLUMN_COUNT;
    cfg_wdata <= CFG_DATA_W'(c);
    @(posedge clk);
    cfg_index <= CFG_BIN_SHIFT;
    cfg_wdata <= CFG_DATA_W'(s);
    @(posedge clk);
    cfg_index <= CFG_SKIP_PEDESTAL;
    cfg_wdata <= CFG_DATA_W'(k);
    @(posedge clk);
    cfg_we <= 1'b0;
    adopt_config(f, r, c, s, k);
  endtask

  // Input side: present the next pending item after its drawn gap and keep it
  // on the bus until it is taken. in_tvalid gets exactly one update per edge.
  always @(posedge clk) begin : drive_items
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tuser  <= '0;
      in_tdata  <= '0;
      send_gap  = 0;
    end else begin
      send_busy = in_tvalid;
      if (in_tvalid && in_tready) begin
        binner_apply(item_on_bus);
        accepted_items++;
        send_busy = 1'b0;
      end
      if (!send_busy) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_items.size() > 0) begin
          item_on_bus = pending_items.pop_front();
          in_tuser <= item_on_bus.mode;
          in_tdata <= IN_DATA_W'(item_on_bus.word);
          send_gap = tx_calm ? 0 : $urandom_range(0, 4);
          send_busy = 1'b1;
        end
      end
      in_tvalid <= send_busy;
    end
  end

  // Result side: compare each bin sum with the oldest pending read. Ready
  // drops for a drawn number of cycles after each result and now and then
  // while nothing is offered.
  always @(posedge clk) begin : check_sums
    if (!rst_n) begin
      out_tready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (sums_due.size() == 0) begin
          report_fault($sformatf("bin_sum %h arrived with no read outstanding", out_tdata));
        end else begin
          want_sum = sums_due.pop_front();
          if (out_tdata !== want_sum)
            report_fault($sformatf("read %0d: bin_sum %h, expected %h",
                                   sums_checked, out_tdata, want_sum));
        end
        sums_checked++;
        recv_stall = rx_calm ? 0 : $urandom_range(0, 4);
      end else if (!rx_calm && recv_stall == 0 && $urandom_range(0, 7) == 0) begin
        recv_stall = $urandom_range(1, 4);
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("pedestal_subtract_pixel_binner test failed");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned phase_no;
    int unsigned pick;
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_wdata  = '0;
    tx_calm    = 1'b0;
    rx_calm    = 1'b0;
    adopt_config(32'(FRAME_COUNT_RST), 32'(ROW_COUNT_RST), 32'(COLUMN_COUNT_RST),
                 32'(BIN_SHIFT_RST), 0);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part under the reset configuration: one frame of 256 x 256,
    // no binning, pedestal subtracted.
    // Smallest calibrated value: zero sample over a full-scale pedestal.
    queue_load(2'd0, 8'd0, 8'd0, 16'hFFFF);
    queue_pixel(2'd0, 8'd0, 8'd0, 16'h0000);
    queue_read(10'd0, 8'd0);
    // Largest calibrated value, at the far corner of the frame.
    queue_load(2'd0, 8'd255, 8'd255, 16'h0000);
    queue_pixel(2'd0, 8'd255, 8'd255, 16'hFFFF);
    queue_read(10'd255, 8'd255);
    // A load to a frame beyond frame_count is still stored, but a pixel there
    // is dropped, so the matching bin at the right edge of the image stays empty.
    queue_load(2'd3, 8'd255, 8'd255, 16'h1234);
    queue_pixel(2'd3, 8'd255, 8'd255, 16'hFFFF);
    queue_read(10'd1023, 8'd255);
    // A second pixel into the same bin accumulates.
    queue_pixel(2'd0, 8'd0, 8'd0, 16'h8000);
    queue_read(10'd0, 8'd0);
    // Clearing empties every bin; pixels after it start from zero.
    queue_clear();
    queue_read(10'd0, 8'd0);
    queue_read(10'd255, 8'd255);
    queue_pixel(2'd0, 8'd0, 8'd0, 16'h0007);
    queue_read(10'd0, 8'd0);
    queue_pixel(2'd0, 8'd128, 8'd64, 16'hFFFF);
    queue_read(10'd64, 8'd128);

    // Random part. Each phase starts from an idle block with a new register
    // setting; the first few cover the saturation corners, later ones are
    // drawn at random.
    phase_no = 0;
    while (queued_items < ITEM_GOAL) begin
      wait_idle();
      case (phase_no)
        0: configure(4, 16, 16, 2, 0);
        1: configure(7, 0, 511, 7, 1);
        2: configure(0, 256, 1, 4, 0);
        3: configure(4, 256, 256, 0, 1);
        4: configure(2, 9, 100, 3, 0);
        5: configure(1, 1, 256, 0, 0);
        default: begin
          configure($urandom_range(0, 7),
                    ($urandom_range(0, 3) == 0) ? $urandom_range(0, 511) : $urandom_range(1, 24),
                    ($urandom_range(0, 3) == 0) ? $urandom_range(0, 511) : $urandom_range(1, 24),
                    $urandom_range(0, 7), $urandom_range(0, 1));
        end
      endcase
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      if (phase_no == 4)
        queue_clear();
      repeat (PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 55)
          queue_random_pixel();
        else if (pick < 75)
          queue_hit_read();
        else
          queue_load(FRAME_W'($urandom), ROW_W'($urandom), COLUMN_W'($urandom),
                     draw_sample());
      end
      // Closing read so the phase ends only once the back end has drained.
      queue_hit_read();
      phase_no++;
    end

    wait_idle();
    if (fault_count == 0) begin
      $display("pedestal_subtract_pixel_binner test passed");
    end else begin
      $display("pedestal_subtract_pixel_binner test failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/psb_pkg.sv
rtl/core/psb_front.sv
rtl/core/psb_queue.sv
rtl/core/psb_back.sv
rtl/core/pedestal_subtract_pixel_binner.sv
verif/tb.sv
